### src/ircfd_pkg.sv
// ----------------------------------------------------------------------------
// IR climate frame decoder package
// Shared types, frame constants and duration window tables.
// ----------------------------------------------------------------------------
package ircfd_pkg;

   localparam int unsigned TOL_MAX   = 50;
   localparam int unsigned TOL_RESET = 25;

   localparam int unsigned PREAMBLE_BYTES = 5;
   localparam int unsigned PAYLOAD_BYTES  = 6;

   localparam logic [7:0] FRAME_BITS = 8'd136;
   localparam logic [7:0] POWER_ON   = 8'h40;
   localparam logic [7:0] PREAMBLE [0:PREAMBLE_BYTES-1] = '{8'h23, 8'hCB, 8'h26, 8'h21, 8'h00};

   localparam logic [4:0] PAYLOAD_FIRST = 5'd5;
   localparam logic [4:0] INVERSE_FIRST = 5'd11;

   localparam logic [3:0] NIB_COOL = 4'd1;
   localparam logic [3:0] NIB_HEAT = 4'd2;
   localparam logic [3:0] NIB_FAN  = 4'd0;
   localparam logic [3:0] NIB_DRY  = 4'd5;

   localparam logic [2:0] MODE_OFF  = 3'd0;
   localparam logic [2:0] MODE_COOL = 3'd1;
   localparam logic [2:0] MODE_HEAT = 3'd2;
   localparam logic [2:0] MODE_FAN  = 3'd3;
   localparam logic [2:0] MODE_DRY  = 3'd4;

   localparam logic [7:0] FAN_BYTE_LOW  = 8'h33;
   localparam logic [7:0] FAN_BYTE_MED  = 8'h35;
   localparam logic [7:0] FAN_BYTE_HIGH = 8'h37;

   localparam logic [1:0] FAN_AUTO = 2'd0;
   localparam logic [1:0] FAN_LOW  = 2'd1;
   localparam logic [1:0] FAN_MED  = 2'd2;
   localparam logic [1:0] FAN_HIGH = 2'd3;

   typedef enum logic [2:0] {
      ERR_NONE,
      ERR_HEADER,
      ERR_BIT_PULSE,
      ERR_STATIC,
      ERR_INVERSE,
      ERR_MODE
   } error_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_FRAME
   } phase_type;

   typedef logic [15:0] dur_type;
   typedef logic [5:0]  tol_type;
   typedef dur_type bound_row_type [0:TOL_MAX];

   typedef struct packed {
      dur_type lo;
      dur_type hi;
   } window_type;

   typedef struct packed {
      window_type hdr_mark;
      window_type hdr_space;
      window_type pulse_mark;
      window_type long_gap;
      window_type short_gap;
   } windows_type;

   function automatic bound_row_type build_row(input int unsigned nom, input bit upper);
      bound_row_type row;
      for (int unsigned t = 0; t <= TOL_MAX; t++) begin
         row[t] = dur_type'(upper ? nom * (100 + t) / 100 : nom * (100 - t) / 100);
      end
      return row;
   endfunction

   localparam bound_row_type HDR_MARK_LO   = build_row(3060, 1'b0);
   localparam bound_row_type HDR_MARK_HI   = build_row(3060, 1'b1);
   localparam bound_row_type HDR_SPACE_LO  = build_row(1580, 1'b0);
   localparam bound_row_type HDR_SPACE_HI  = build_row(1580, 1'b1);
   localparam bound_row_type PULSE_MARK_LO = build_row(350, 1'b0);
   localparam bound_row_type PULSE_MARK_HI = build_row(350, 1'b1);
   localparam bound_row_type LONG_GAP_LO   = build_row(1150, 1'b0);
   localparam bound_row_type LONG_GAP_HI   = build_row(1150, 1'b1);
   localparam bound_row_type SHORT_GAP_LO  = build_row(390, 1'b0);
   localparam bound_row_type SHORT_GAP_HI  = build_row(390, 1'b1);

   // clamp to the top of the table
   function automatic windows_type windows_at(input tol_type tol);
      tol_type     t;
      windows_type w;
      t = (tol > tol_type'(TOL_MAX)) ? tol_type'(TOL_MAX) : tol;
      w.hdr_mark   = '{lo: HDR_MARK_LO[t],   hi: HDR_MARK_HI[t]};
      w.hdr_space  = '{lo: HDR_SPACE_LO[t],  hi: HDR_SPACE_HI[t]};
      w.pulse_mark = '{lo: PULSE_MARK_LO[t], hi: PULSE_MARK_HI[t]};
      w.long_gap   = '{lo: LONG_GAP_LO[t],   hi: LONG_GAP_HI[t]};
      w.short_gap  = '{lo: SHORT_GAP_LO[t],  hi: SHORT_GAP_HI[t]};
      return w;
   endfunction

   function automatic logic in_window(input dur_type d, input window_type w);
      return (d >= w.lo) && (d <= w.hi);
   endfunction

endpackage

### src/ir_climate_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// IR climate frame decoder core
// Matches mark/space pairs against header and bit timing, assembles the
// frame bytes, checks preamble and inverse bytes and reports one result.
// ----------------------------------------------------------------------------
// Latency: a result appears in the cycle after the request that ends a frame.
// Throughput: one request per cycle; the only stall comes from a held result.
// Window bounds are looked up on a tolerance write and held in registers.
// Reset (synchronous): idle, counters and check flags cleared, tolerance 25,
// no result pending. Payload bytes are not reset.
module ir_climate_frame_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [5:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_mark_us,
   input  logic [15:0] req_space_us,
   input  logic        req_first_pair,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_frame_ok,
   output logic [2:0]  rsp_error_code,
   output logic [2:0]  rsp_mode_code,
   output logic [4:0]  rsp_target_temp,
   output logic [1:0]  rsp_fan_setting
);
   import ircfd_pkg::*;

   windows_type win_ff, win_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  bit_index_ff, bit_index_in;
   logic [7:0]  shift_ff, shift_in;
   logic        static_bad_ff, static_bad_in;
   logic        inverse_bad_ff, inverse_bad_in;
   logic [7:0]  payload_ff [0:PAYLOAD_BYTES-1];

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_frame_ok_ff, rsp_frame_ok_in;
   error_type   rsp_error_ff, rsp_error_in;
   logic [2:0]  rsp_mode_ff, rsp_mode_in;
   logic [4:0]  rsp_temp_ff, rsp_temp_in;
   logic [1:0]  rsp_fan_ff, rsp_fan_in;

   logic        accept;
   logic        hdr_ok, mark_ok, one_ok, zero_ok, bit_ok, bit_val;
   logic [7:0]  shift_next, idx_next;
   logic [4:0]  byte_index;
   logic [2:0]  pay_wr_addr, pay_rd_addr;
   logic        pay_we;
   logic        emit, done;
   error_type   early_err;
   logic [3:0]  nib;

   assign accept    = req_valid & ~req_stall;
   assign req_stall = rsp_valid_ff & rsp_stall;

   assign hdr_ok  = in_window(req_mark_us, win_ff.hdr_mark) &
                    in_window(req_space_us, win_ff.hdr_space);
   assign mark_ok = in_window(req_mark_us, win_ff.pulse_mark);
   assign one_ok  = mark_ok & in_window(req_space_us, win_ff.long_gap);
   assign zero_ok = mark_ok & in_window(req_space_us, win_ff.short_gap);
   assign bit_ok  = one_ok | zero_ok;
   assign bit_val = one_ok;

   assign shift_next  = {bit_val, shift_ff[7:1]};
   assign idx_next    = bit_index_ff + 8'd1;
   assign byte_index  = idx_next[7:3] - 5'd1;
   assign pay_wr_addr = 3'(byte_index - PAYLOAD_FIRST);
   assign pay_rd_addr = 3'(byte_index - INVERSE_FIRST);

   assign win_in = csr_write_enable ? windows_at(csr_write_data) : win_ff;

   // next state
   always_comb begin
      phase_in       = phase_ff;
      bit_index_in   = bit_index_ff;
      shift_in       = shift_ff;
      static_bad_in  = static_bad_ff;
      inverse_bad_in = inverse_bad_ff;
      pay_we         = 1'b0;
      emit           = 1'b0;
      done           = 1'b0;
      early_err      = ERR_NONE;
      if (accept) begin
         if (req_first_pair) begin
            bit_index_in   = 8'd0;
            shift_in       = 8'd0;
            static_bad_in  = 1'b0;
            inverse_bad_in = 1'b0;
            if (hdr_ok) begin
               phase_in = PH_FRAME;
            end else begin
               phase_in  = PH_IDLE;
               emit      = 1'b1;
               early_err = ERR_HEADER;
            end
         end else if (phase_ff == PH_FRAME) begin
            if (!bit_ok) begin
               phase_in  = PH_IDLE;
               emit      = 1'b1;
               early_err = ERR_BIT_PULSE;
            end else begin
               shift_in     = shift_next;
               bit_index_in = idx_next;
               if (idx_next[2:0] == 3'd0) begin
                  shift_in = 8'd0;
                  if (byte_index < 5'(PREAMBLE_BYTES)) begin
                     if (shift_next != PREAMBLE[byte_index[2:0]]) static_bad_in = 1'b1;
                  end else if (byte_index < INVERSE_FIRST) begin
                     pay_we = 1'b1;
                  end else begin
                     if (shift_next != ~payload_ff[pay_rd_addr]) inverse_bad_in = 1'b1;
                  end
               end
               if (idx_next >= FRAME_BITS) begin
                  phase_in = PH_IDLE;
                  emit     = 1'b1;
                  done     = 1'b1;
               end
            end
         end
      end
   end

   // result decode
   always_comb begin
      nib             = payload_ff[1][3:0];
      rsp_frame_ok_in = 1'b0;
      rsp_error_in    = early_err;
      rsp_mode_in     = MODE_OFF;
      rsp_temp_in     = 5'd0;
      rsp_fan_in      = FAN_AUTO;
      if (done) begin
         if (static_bad_in) begin
            rsp_error_in = ERR_STATIC;
         end else if (inverse_bad_in) begin
            rsp_error_in = ERR_INVERSE;
         end else begin
            rsp_frame_ok_in = 1'b1;
            rsp_error_in    = ERR_NONE;
            if (payload_ff[0] == POWER_ON) begin
               case (nib)
                  NIB_COOL: rsp_mode_in = MODE_COOL;
                  NIB_HEAT: rsp_mode_in = MODE_HEAT;
                  NIB_FAN:  rsp_mode_in = MODE_FAN;
                  NIB_DRY:  rsp_mode_in = MODE_DRY;
                  default: begin
                     rsp_frame_ok_in = 1'b0;
                     rsp_error_in    = ERR_MODE;
                  end
               endcase
            end
            if (rsp_frame_ok_in) begin
               rsp_temp_in = {1'b1, payload_ff[1][7:4]};
               case (payload_ff[2])
                  FAN_BYTE_LOW:  rsp_fan_in = FAN_LOW;
                  FAN_BYTE_MED:  rsp_fan_in = FAN_MED;
                  FAN_BYTE_HIGH: rsp_fan_in = FAN_HIGH;
                  default:       rsp_fan_in = FAN_AUTO;
               endcase
            end
         end
      end
      rsp_valid_in = emit | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff         <= windows_at(tol_type'(TOL_RESET));
         phase_ff       <= PH_IDLE;
         bit_index_ff   <= 8'd0;
         shift_ff       <= 8'd0;
         static_bad_ff  <= 1'b0;
         inverse_bad_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         win_ff         <= win_in;
         phase_ff       <= phase_in;
         bit_index_ff   <= bit_index_in;
         shift_ff       <= shift_in;
         static_bad_ff  <= static_bad_in;
         inverse_bad_ff <= inverse_bad_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pay_we) begin
         payload_ff[pay_wr_addr] <= shift_next;
      end
   end

   // hold the result until taken
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_frame_ok_ff <= rsp_frame_ok_in;
         rsp_error_ff    <= rsp_error_in;
         rsp_mode_ff     <= rsp_mode_in;
         rsp_temp_ff     <= rsp_temp_in;
         rsp_fan_ff      <= rsp_fan_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frame_ok    = rsp_frame_ok_ff;
   assign rsp_error_code  = rsp_error_ff;
   assign rsp_mode_code   = rsp_mode_ff;
   assign rsp_target_temp = rsp_temp_ff;
   assign rsp_fan_setting = rsp_fan_ff;

endmodule

### tb/ir_climate_frame_decoder_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IR climate frame decoder core testbench
// Feeds mark/space pairs through the request channel: directed header, bit,
// truncation, tolerance and frame check cases, a long result hold-off, then
// random frame traffic under three idling profiles. A predictor decodes each
// accepted request and every result is compared field by field against it.
// ----------------------------------------------------------------------------
module ir_climate_frame_decoder_core_tb;
   import ircfd_pkg::*;

   localparam int unsigned NOM_HDR_MARK   = 3060;
   localparam int unsigned NOM_HDR_SPACE  = 1580;
   localparam int unsigned NOM_PULSE_MARK = 350;
   localparam int unsigned NOM_LONG_GAP   = 1150;
   localparam int unsigned NOM_SHORT_GAP  = 390;
   localparam logic [3:0]  NIB_BOGUS      = 4'hC;

   typedef logic [16:0][7:0] frame_type;

   typedef struct packed {
      logic       frame_ok;
      error_type  error_code;
      logic [2:0] mode_code;
      logic [4:0] target_temp;
      logic [1:0] fan_setting;
   } frame_result_type;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [5:0]  csr_write_data;
   logic        req_valid;
   logic        req_stall;
   logic [15:0] req_mark_us;
   logic [15:0] req_space_us;
   logic        req_first_pair;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_frame_ok;
   logic [2:0]  rsp_error_code;
   logic [2:0]  rsp_mode_code;
   logic [4:0]  rsp_target_temp;
   logic [1:0]  rsp_fan_setting;

   // decoder state mirror
   tol_type     tolerance;
   phase_type   rx_phase;
   int unsigned rx_bits;
   logic [7:0]  rx_shift;
   logic [7:0]  rx_payload [0:PAYLOAD_BYTES-1];
   logic        rx_static_bad;
   logic        rx_inverse_bad;

   frame_result_type pending_results [$];
   int send_idle_pct = 19;
   int recv_idle_pct = 77;
   int hold_left     = 0;
   int quiet_left    = 0;
   bit hold_req      = 1'b0;
   int sent_count    = 0;
   int mismatch_count = 0;

   ir_climate_frame_decoder_core dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mark_us     (req_mark_us),
      .req_space_us    (req_space_us),
      .req_first_pair  (req_first_pair),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_frame_ok    (rsp_frame_ok),
      .rsp_error_code  (rsp_error_code),
      .rsp_mode_code   (rsp_mode_code),
      .rsp_target_temp (rsp_target_temp),
      .rsp_fan_setting (rsp_fan_setting)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("ir_climate_frame_decoder_core_tb: errors");
      $finish;
   end

   function automatic int unsigned tol_used();
      if (tolerance > TOL_MAX) return TOL_MAX;
      return tolerance;
   endfunction

   function automatic int unsigned win_lo(input int unsigned nom);
      return nom * (100 - tol_used()) / 100;
   endfunction

   function automatic int unsigned win_hi(input int unsigned nom);
      return nom * (100 + tol_used()) / 100;
   endfunction

   function automatic bit fits(input int unsigned d, input int unsigned nom);
      return (d >= win_lo(nom)) && (d <= win_hi(nom));
   endfunction

   task automatic post_result(input logic ok, input error_type err, input logic [2:0] mode,
                              input logic [4:0] temp, input logic [1:0] fan);
      frame_result_type r;
      r.frame_ok    = ok;
      r.error_code  = err;
      r.mode_code   = mode;
      r.target_temp = temp;
      r.fan_setting = fan;
      pending_results.push_back(r);
      rx_phase = PH_IDLE;
   endtask

   task automatic post_error(input error_type err);
      post_result(1'b0, err, MODE_OFF, 5'd0, FAN_AUTO);
   endtask

   task automatic close_frame();
      logic [3:0] nib;
      logic [2:0] mode;
      logic [1:0] fan;
      bit         bad_mode;
      bad_mode = 1'b0;
      nib  = rx_payload[1][3:0];
      mode = MODE_OFF;
      if (rx_payload[0] == POWER_ON) begin
         case (nib)
            NIB_COOL: mode = MODE_COOL;
            NIB_HEAT: mode = MODE_HEAT;
            NIB_FAN:  mode = MODE_FAN;
            NIB_DRY:  mode = MODE_DRY;
            default:  bad_mode = 1'b1;
         endcase
      end
      case (rx_payload[2])
         FAN_BYTE_LOW:  fan = FAN_LOW;
         FAN_BYTE_MED:  fan = FAN_MED;
         FAN_BYTE_HIGH: fan = FAN_HIGH;
         default:       fan = FAN_AUTO;
      endcase
      if (rx_static_bad) post_error(ERR_STATIC);
      else if (rx_inverse_bad) post_error(ERR_INVERSE);
      else if (bad_mode) post_error(ERR_MODE);
      else post_result(1'b1, ERR_NONE, mode, 5'(rx_payload[1][7:4]) + 5'd16, fan);
   endtask

   task automatic decode_pair(input logic [15:0] mark, input logic [15:0] space,
                              input logic first);
      logic        bitv;
      int unsigned idx;
      if (first) begin
         rx_bits        = 0;
         rx_shift       = 8'h00;
         rx_static_bad  = 1'b0;
         rx_inverse_bad = 1'b0;
         if (fits(mark, NOM_HDR_MARK) && fits(space, NOM_HDR_SPACE)) rx_phase = PH_FRAME;
         else post_error(ERR_HEADER);
         return;
      end
      if (rx_phase != PH_FRAME) return;
      if (fits(mark, NOM_PULSE_MARK) && fits(space, NOM_LONG_GAP)) bitv = 1'b1;
      else if (fits(mark, NOM_PULSE_MARK) && fits(space, NOM_SHORT_GAP)) bitv = 1'b0;
      else begin
         post_error(ERR_BIT_PULSE);
         return;
      end
      rx_shift = {bitv, rx_shift[7:1]};
      rx_bits++;
      if (rx_bits % 8 == 0) begin
         idx = rx_bits / 8 - 1;
         if (idx < PREAMBLE_BYTES) begin
            if (rx_shift != PREAMBLE[idx]) rx_static_bad = 1'b1;
         end else if (idx < INVERSE_FIRST) begin
            rx_payload[idx - PAYLOAD_FIRST] = rx_shift;
         end else if (rx_shift != ~rx_payload[idx - INVERSE_FIRST]) begin
            rx_inverse_bad = 1'b1;
         end
         rx_shift = 8'h00;
      end
      if (rx_bits >= FRAME_BITS) close_frame();
   endtask

   task automatic compare_field(input string label, input logic [7:0] want,
                                input logic [7:0] got);
      if (want !== got) begin
         $display("%0t ns: %s expected %0d actual %0d", $time, label, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t ns: result expected none actual frame_ok %0d error_code %0d",
                     $time, rsp_frame_ok, rsp_error_code);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            compare_field("frame_ok", 8'(want.frame_ok), 8'(rsp_frame_ok));
            compare_field("error_code", 8'(want.error_code), 8'(rsp_error_code));
            compare_field("mode_code", 8'(want.mode_code), 8'(rsp_mode_code));
            compare_field("target_temp", 8'(want.target_temp), 8'(rsp_target_temp));
            compare_field("fan_setting", 8'(want.fan_setting), 8'(rsp_fan_setting));
         end
      end
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_left = 160;
            hold_req  = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else if (quiet_left > 0) begin
            rsp_stall = 1'b0;
            quiet_left--;
         end else begin
            if ($urandom_range(199) == 0) quiet_left = $urandom_range(40, 10);
            rsp_stall = ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   task automatic send_pair(input logic [15:0] mark, input logic [15:0] space,
                            input logic first);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid      = 1'b1;
      req_mark_us    = mark;
      req_space_us   = space;
      req_first_pair = first;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_pair(mark, space, first);
      sent_count++;
      @(negedge clock);
   endtask

   function automatic logic [15:0] dur_in(input int unsigned nom);
      int unsigned pick;
      pick = $urandom_range(7);
      if (pick == 0) return 16'(win_lo(nom));
      if (pick == 1) return 16'(win_hi(nom));
      return 16'($urandom_range(win_hi(nom), win_lo(nom)));
   endfunction

   function automatic logic [15:0] dur_outside(input int unsigned nom);
      if (win_lo(nom) > 0 && $urandom_range(1) == 1)
         return 16'($urandom_range(win_lo(nom) - 1, 0));
      return 16'($urandom_range(65535, win_hi(nom) + 1));
   endfunction

   function automatic frame_type make_frame(input logic [7:0] power,
                                            input logic [7:0] setting,
                                            input logic [7:0] fan);
      frame_type f;
      for (int i = 0; i < PREAMBLE_BYTES; i++) f[i] = PREAMBLE[i];
      f[5] = power;
      f[6] = setting;
      f[7] = fan;
      for (int i = 8; i < 11; i++) f[i] = 8'($urandom);
      for (int i = 0; i < PAYLOAD_BYTES; i++) f[INVERSE_FIRST + i] = ~f[PAYLOAD_FIRST + i];
      return f;
   endfunction

   function automatic frame_type random_frame();
      frame_type  f;
      logic [7:0] power;
      logic [7:0] fan;
      logic [3:0] nib;
      int         idx;
      power = ($urandom_range(3) != 0) ? POWER_ON : 8'($urandom);
      case ($urandom_range(4))
         0:       nib = NIB_COOL;
         1:       nib = NIB_HEAT;
         2:       nib = NIB_FAN;
         3:       nib = NIB_DRY;
         default: nib = 4'($urandom);
      endcase
      case ($urandom_range(3))
         0:       fan = FAN_BYTE_LOW;
         1:       fan = FAN_BYTE_MED;
         2:       fan = FAN_BYTE_HIGH;
         default: fan = 8'($urandom);
      endcase
      f = make_frame(power, {4'($urandom), nib}, fan);
      if ($urandom_range(9) == 0) begin
         idx = $urandom_range(PREAMBLE_BYTES - 1);
         f[idx] = f[idx] ^ (8'h01 << $urandom_range(7));
      end
      if ($urandom_range(9) == 0) begin
         idx = INVERSE_FIRST + $urandom_range(PAYLOAD_BYTES - 1);
         f[idx] = f[idx] ^ (8'h01 << $urandom_range(7));
      end
      return f;
   endfunction

   task automatic send_frame(input frame_type f, input int nbits);
      logic b;
      send_pair(dur_in(NOM_HDR_MARK), dur_in(NOM_HDR_SPACE), 1'b1);
      for (int i = 0; i < nbits; i++) begin
         b = f[i / 8][i % 8];
         send_pair(dur_in(NOM_PULSE_MARK), dur_in(b ? NOM_LONG_GAP : NOM_SHORT_GAP), 1'b0);
      end
   endtask

   task automatic send_bad_header();
      case ($urandom_range(2))
         0:       send_pair(dur_outside(NOM_HDR_MARK), dur_in(NOM_HDR_SPACE), 1'b1);
         1:       send_pair(dur_in(NOM_HDR_MARK), dur_outside(NOM_HDR_SPACE), 1'b1);
         default: send_pair(dur_outside(NOM_HDR_MARK), dur_outside(NOM_HDR_SPACE), 1'b1);
      endcase
   endtask

   task automatic send_bad_bit();
      int unsigned gap_lo;
      int unsigned gap_hi;
      gap_lo = win_hi(NOM_SHORT_GAP) + 1;
      gap_hi = win_lo(NOM_LONG_GAP);
      case ($urandom_range(3))
         0: send_pair(dur_outside(NOM_PULSE_MARK), dur_in(NOM_LONG_GAP), 1'b0);
         1: send_pair(dur_in(NOM_PULSE_MARK),
                      16'($urandom_range(win_lo(NOM_SHORT_GAP) - 1, 0)), 1'b0);
         2: send_pair(dur_in(NOM_PULSE_MARK),
                      16'($urandom_range(65535, win_hi(NOM_LONG_GAP) + 1)), 1'b0);
         default: begin
            if (gap_lo < gap_hi)
               send_pair(dur_in(NOM_PULSE_MARK), 16'($urandom_range(gap_hi - 1, gap_lo)), 1'b0);
            else
               send_pair(dur_in(NOM_PULSE_MARK), 16'(win_hi(NOM_LONG_GAP) + 1), 1'b0);
         end
      endcase
   endtask

   task automatic settle();
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_tolerance(input tol_type value);
      settle();
      csr_write_enable = 1'b1;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      tolerance        = value;
   endtask

   task automatic test_idle_pairs();
      send_pair(16'h0000, 16'h0000, 1'b0);
      send_pair(16'hFFFF, 16'hFFFF, 1'b0);
      send_pair(16'(NOM_PULSE_MARK), 16'(NOM_LONG_GAP), 1'b0);
      settle();
   endtask

   task automatic test_header_errors();
      send_pair(16'h0000, 16'h0000, 1'b1);
      send_pair(16'hFFFF, 16'hFFFF, 1'b1);
      send_pair(16'(win_lo(NOM_HDR_MARK)), 16'(win_hi(NOM_HDR_SPACE)), 1'b1);
      send_pair(16'(win_lo(NOM_HDR_MARK) - 1), 16'(NOM_HDR_SPACE), 1'b1);
      send_pair(16'(NOM_HDR_MARK), 16'(win_hi(NOM_HDR_SPACE) + 1), 1'b1);
      settle();
   endtask

   task automatic test_bit_errors();
      send_pair(16'(NOM_HDR_MARK), 16'(NOM_HDR_SPACE), 1'b1);
      send_pair(16'(NOM_PULSE_MARK), 16'(NOM_LONG_GAP), 1'b0);
      send_pair(16'h0000, 16'h0000, 1'b0);
      send_pair(16'(NOM_HDR_MARK), 16'(NOM_HDR_SPACE), 1'b1);
      send_pair(16'hFFFF, 16'(NOM_SHORT_GAP), 1'b0);
      send_pair(16'(NOM_HDR_MARK), 16'(NOM_HDR_SPACE), 1'b1);
      send_pair(16'(NOM_PULSE_MARK), 16'hFFFF, 1'b0);
      settle();
   endtask

   task automatic test_truncated_frame();
      send_frame(random_frame(), 9);
      send_frame(random_frame(), 2);
      send_pair(16'(NOM_HDR_MARK), 16'(NOM_HDR_SPACE), 1'b1);
      send_bad_bit();
      send_pair(16'(NOM_PULSE_MARK), 16'(NOM_LONG_GAP), 1'b0);
      settle();
   endtask

   // zeros sent with a space inside both bit windows decode as ones
   task automatic test_ambiguous_bit();
      frame_type f;
      logic      b;
      set_tolerance(tol_type'(TOL_MAX));
      f = make_frame(POWER_ON, {4'h3, NIB_HEAT}, FAN_BYTE_MED);
      send_pair(16'(NOM_HDR_MARK), 16'(NOM_HDR_SPACE), 1'b1);
      for (int i = 0; i < FRAME_BITS; i++) begin
         b = f[i / 8][i % 8];
         send_pair(16'(NOM_PULSE_MARK),
                   b ? 16'(NOM_LONG_GAP) : 16'(win_lo(NOM_LONG_GAP)), 1'b0);
      end
      settle();
   endtask

   task automatic test_tolerance_clamp();
      set_tolerance(6'h3F);
      send_pair(16'(win_lo(NOM_HDR_MARK)), 16'(win_hi(NOM_HDR_SPACE)), 1'b1);
      send_pair(16'(win_lo(NOM_PULSE_MARK)), 16'(win_hi(NOM_LONG_GAP)), 1'b0);
      send_pair(16'(win_lo(NOM_PULSE_MARK) - 1), 16'(NOM_LONG_GAP), 1'b0);
      send_pair(16'(win_lo(NOM_HDR_MARK) - 1), 16'(NOM_HDR_SPACE), 1'b1);
      settle();
   endtask

   task automatic test_frame_checks();
      frame_type f;
      set_tolerance(tol_type'(TOL_RESET));
      send_frame(make_frame(POWER_ON, {4'hF, NIB_COOL}, FAN_BYTE_LOW), FRAME_BITS);
      f = make_frame(POWER_ON, {4'h0, NIB_BOGUS}, FAN_BYTE_MED);
      f[1]  = f[1] ^ 8'h01;
      f[12] = f[12] ^ 8'h80;
      send_frame(f, FRAME_BITS);
      f = make_frame(POWER_ON, {4'h2, NIB_BOGUS}, FAN_BYTE_HIGH);
      f[16] = f[16] ^ 8'h10;
      send_frame(f, FRAME_BITS);
      send_frame(make_frame(POWER_ON, {4'h5, NIB_BOGUS}, 8'h00), FRAME_BITS);
      settle();
   endtask

   task automatic test_backpressure();
      hold_req = 1'b1;
      repeat (24) send_bad_header();
      settle();
   endtask

   task automatic test_random_phase(input int s_pct, input int r_pct, input tol_type tol,
                                    input int budget);
      int first_item;
      int pick;
      set_tolerance(tol);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      first_item    = sent_count;
      while (sent_count - first_item < budget) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            send_frame(random_frame(), FRAME_BITS);
         end else if (pick < 60) begin
            send_frame(random_frame(),
                       ($urandom_range(1) == 1) ? $urandom_range(15, 0) : $urandom_range(135, 0));
            send_bad_bit();
         end else if (pick < 75) begin
            send_bad_header();
         end else if (pick < 88) begin
            send_frame(random_frame(), $urandom_range(135, 1));
         end else begin
            repeat ($urandom_range(4, 1))
               send_pair(16'($urandom), 16'($urandom), $urandom_range(7) == 0);
         end
      end
      settle();
   endtask

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = 6'd0;
      req_valid        = 1'b0;
      req_mark_us      = 16'h0000;
      req_space_us     = 16'h0000;
      req_first_pair   = 1'b0;
      tolerance        = tol_type'(TOL_RESET);
      rx_phase         = PH_IDLE;
      rx_bits          = 0;
      rx_shift         = 8'h00;
      rx_static_bad    = 1'b0;
      rx_inverse_bad   = 1'b0;
      for (int i = 0; i < PAYLOAD_BYTES; i++) rx_payload[i] = 8'h00;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_idle_pairs();
      test_header_errors();
      test_bit_errors();
      test_truncated_frame();
      test_ambiguous_bit();
      test_tolerance_clamp();
      test_frame_checks();
      test_backpressure();
      test_random_phase(19, 77, 6'h3F, 50);
      test_random_phase(77, 19, 6'd0, 50);
      test_random_phase(0, 0, tol_type'($urandom_range(49, 1)), 50);

      settle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ir_climate_frame_decoder_core_tb: clean");
      end else begin
         $display("ir_climate_frame_decoder_core_tb: errors");
      end
      $finish;
   end

endmodule
